// ===== design/zcpa_pkg.sv =====
// Package for the zero-crossing plane average block.
// Holds field widths, register indexes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package zcpa_pkg;

	localparam int SampleWidth   = 16;
	localparam int PlaneWidth    = 10;
	localparam int CoordWidth    = 10;
	localparam int HalfWidth     = 9;
	localparam int MeanWidth     = 18;
	localparam int CountWidth    = 24;
	localparam int SumWidth      = 42;
	localparam int StepWidth     = $clog2(SumWidth + 1);
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 10;

	localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

	localparam int FirstPlaneReset  = 10;
	localparam int FinalPlaneMargin = 12;

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] CfgCenterX   = 3'd0;
	localparam logic [CfgIndexWidth-1:0] CfgCenterY   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] CfgHalfX     = 3'd2;
	localparam logic [CfgIndexWidth-1:0] CfgHalfY     = 3'd3;
	localparam logic [CfgIndexWidth-1:0] CfgFirstPlane = 3'd4;
	localparam logic [CfgIndexWidth-1:0] CfgFinalPlane = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FRAC,
		ST_MEAN_START,
		ST_MEAN_R,
		ST_MEAN_F,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DIV_FRAC,
		DIV_MEAN_R,
		DIV_MEAN_F
	} div_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     div_start;
		div_sel_t div_sel;
		logic     accumulate;
		logic     cap_mean_r;
		logic     load_out;
		logic     clear_acc;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic hit;
		logic last;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/zcpa_if.sv =====
// Handshake channels of the zero-crossing plane average block.
// Depends on zcpa_pkg for the field widths.
interface zcpa_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [zcpa_pkg::SampleWidth-1:0]  lower_sample;
	logic signed [zcpa_pkg::SampleWidth-1:0]  upper_sample;
	logic        [zcpa_pkg::PlaneWidth-1:0]   plane_index;
	logic        [zcpa_pkg::CoordWidth-1:0]   column_x;
	logic        [zcpa_pkg::CoordWidth-1:0]   column_y;
	logic                                     last_item;

	modport source (
		output valid, lower_sample, upper_sample, plane_index, column_x, column_y,
		       last_item,
		input  ready
	);
	modport sink (
		input  valid, lower_sample, upper_sample, plane_index, column_x, column_y,
		       last_item,
		output ready
	);
endinterface

interface zcpa_out_if;
	logic                               valid;
	logic                               ready;
	logic [zcpa_pkg::MeanWidth-1:0]     mean_rising;
	logic [zcpa_pkg::MeanWidth-1:0]     mean_falling;
	logic [zcpa_pkg::CountWidth-1:0]    rising_total;
	logic [zcpa_pkg::CountWidth-1:0]    falling_total;
	logic                               rising_valid;
	logic                               falling_valid;

	modport source (
		output valid, mean_rising, mean_falling, rising_total, falling_total,
		       rising_valid, falling_valid,
		input  ready
	);
	modport sink (
		input  valid, mean_rising, mean_falling, rising_total, falling_total,
		       rising_valid, falling_valid,
		output ready
	);
endinterface

// ===== design/zcpa_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on zcpa_pkg for the sum, count and step counter widths.
module zcpa_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [zcpa_pkg::CountWidth-1:0]    rem_init,
	input  logic [zcpa_pkg::SumWidth-1:0]      dividend,
	input  logic [zcpa_pkg::CountWidth-1:0]    divisor,
	input  logic [zcpa_pkg::StepWidth-1:0]     steps,
	output logic [zcpa_pkg::SumWidth-1:0]      quotient,
	output logic                               done
);
	import zcpa_pkg::*;

	logic [StepWidth-1:0]  steps_q;
	logic [CountWidth-1:0] rem_q;
	logic [CountWidth-1:0] divisor_q;
	logic [SumWidth-1:0]   dividend_q;
	logic [SumWidth-1:0]   quotient_q;
	logic [CountWidth:0]   trial;
	logic                  ge;
	logic [CountWidth-1:0] rem_next;

	// The remainder stays below the divisor, so the shifted trial value fits
	// one bit above the count width.
	always_comb begin
		trial    = {rem_q, dividend_q[SumWidth-1]};
		ge       = trial >= {1'b0, divisor_q};
		rem_next = ge ? CountWidth'(trial - {1'b0, divisor_q}) : trial[CountWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= steps;
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q      <= rem_init;
			dividend_q <= dividend;
			divisor_q  <= divisor;
			quotient_q <= '0;
		end else if (steps_q != '0) begin
			rem_q      <= rem_next;
			dividend_q <= {dividend_q[SumWidth-2:0], 1'b0};
			quotient_q <= {quotient_q[SumWidth-2:0], ge};
		end
	end

	assign quotient = quotient_q;
	assign done     = steps_q == '0;

endmodule

// ===== design/zcpa_datapath.sv =====
// Datapath of the zero-crossing plane average block: configuration registers,
// item screening, accumulators, the shared divider and the output register.
// Depends on zcpa_pkg, zcpa_if and zcpa_divider.
module zcpa_datapath #(
	parameter int PLANES        = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	zcpa_in_if.sink                               samples,
	zcpa_out_if.source                            averages,
	input  logic                                  cfg_write_en,
	input  logic [zcpa_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [zcpa_pkg::CfgDataWidth-1:0]     cfg_data,
	input  zcpa_pkg::ctrl_cmd_t                   cmd,
	output zcpa_pkg::dp_status_t                  status
);
	import zcpa_pkg::*;

	localparam int PosWidth = PlaneWidth + FRACTION_BITS;
	localparam logic [PlaneWidth-1:0] FinalPlaneReset = PlaneWidth'(PLANES - FinalPlaneMargin);

	logic [CoordWidth-1:0] center_x_q, center_y_q;
	logic [HalfWidth-1:0]  half_x_q, half_y_q;
	logic [PlaneWidth-1:0] first_plane_q, final_plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			half_x_q      <= '0;
			half_y_q      <= '0;
			first_plane_q <= PlaneWidth'(FirstPlaneReset);
			final_plane_q <= FinalPlaneReset;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CfgCenterX:    center_x_q    <= cfg_data[CoordWidth-1:0];
				CfgCenterY:    center_y_q    <= cfg_data[CoordWidth-1:0];
				CfgHalfX:      half_x_q      <= cfg_data[HalfWidth-1:0];
				CfgHalfY:      half_y_q      <= cfg_data[HalfWidth-1:0];
				CfgFirstPlane: first_plane_q <= cfg_data[PlaneWidth-1:0];
				CfgFinalPlane: final_plane_q <= cfg_data[PlaneWidth-1:0];
				default: ;
			endcase
		end
	end

	// Item screening at acceptance.
	logic                         accept;
	logic signed [CoordWidth+1:0] x_lo, x_hi, y_lo, y_hi, cx, cy;
	logic                         use_item, rise, fall;
	logic [SampleWidth-1:0]       num, other;

	always_comb begin
		accept = samples.valid && cmd.in_ready;
		// Window bounds are formed two bits wider so they never wrap.
		cx   = $signed({2'b00, samples.column_x});
		cy   = $signed({2'b00, samples.column_y});
		x_lo = $signed({2'b00, center_x_q}) - $signed({3'b000, half_x_q});
		x_hi = $signed({2'b00, center_x_q}) + $signed({3'b000, half_x_q});
		y_lo = $signed({2'b00, center_y_q}) - $signed({3'b000, half_y_q});
		y_hi = $signed({2'b00, center_y_q}) + $signed({3'b000, half_y_q});
		use_item = cx >= x_lo && cx <= x_hi && cy >= y_lo && cy <= y_hi
			&& samples.plane_index >= first_plane_q
			&& samples.plane_index <= final_plane_q;
		rise  = samples.lower_sample <= $signed(16'sd0)
			&& samples.upper_sample > $signed(16'sd0);
		fall  = samples.lower_sample >= $signed(16'sd0)
			&& samples.upper_sample < $signed(16'sd0);
		num   = rise ? SampleWidth'(-samples.lower_sample) : SampleWidth'(samples.lower_sample);
		other = rise ? SampleWidth'(samples.upper_sample) : SampleWidth'(-samples.upper_sample);
	end

	assign samples.ready = cmd.in_ready;

	logic                   rise_q, fall_q, last_q;
	logic [PlaneWidth-1:0]  plane_q;
	logic [SampleWidth-1:0] num_q;
	logic [SampleWidth:0]   den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= 1'b0;
			fall_q <= 1'b0;
			last_q <= 1'b0;
		end else if (accept) begin
			rise_q <= use_item && rise;
			fall_q <= use_item && fall;
			last_q <= samples.last_item;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plane_q <= samples.plane_index;
			num_q   <= num;
			den_q   <= {1'b0, num} + {1'b0, other};
		end
	end

	// Accumulators.
	logic [SumWidth-1:0]   rising_sum_q, falling_sum_q;
	logic [CountWidth-1:0] rising_count_q, falling_count_q;
	logic [SumWidth-1:0]   quotient;
	logic [PosWidth-1:0]   pos;
	logic [SumWidth-1:0]   pos_ext;

	// The fraction is below one, so the position is a plain concatenation.
	assign pos     = {plane_q, quotient[FRACTION_BITS-1:0]};
	assign pos_ext = {{(SumWidth-PosWidth){1'b0}}, pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_sum_q    <= '0;
			falling_sum_q   <= '0;
			rising_count_q  <= '0;
			falling_count_q <= '0;
		end else if (cmd.clear_acc) begin
			rising_sum_q    <= '0;
			falling_sum_q   <= '0;
			rising_count_q  <= '0;
			falling_count_q <= '0;
		end else if (cmd.accumulate) begin
			if (rise_q && rising_count_q != CountMax) begin
				rising_sum_q   <= rising_sum_q + pos_ext;
				rising_count_q <= rising_count_q + 1'b1;
			end
			if (fall_q && falling_count_q != CountMax) begin
				falling_sum_q   <= falling_sum_q + pos_ext;
				falling_count_q <= falling_count_q + 1'b1;
			end
		end
	end

	// Divider operand selection.
	logic [CountWidth-1:0] div_rem_init, div_divisor;
	logic [SumWidth-1:0]   div_dividend;
	logic [StepWidth-1:0]  div_steps;
	logic                  div_done;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_FRAC: begin
				// Start from the magnitude as a partial remainder: only the
				// fraction bits are developed.
				div_rem_init = CountWidth'(num_q);
				div_dividend = '0;
				div_divisor  = CountWidth'(den_q);
				div_steps    = StepWidth'(FRACTION_BITS);
			end
			DIV_MEAN_R: begin
				div_rem_init = '0;
				div_dividend = rising_sum_q;
				div_divisor  = rising_count_q;
				div_steps    = StepWidth'(SumWidth);
			end
			DIV_MEAN_F: begin
				div_rem_init = '0;
				div_dividend = falling_sum_q;
				div_divisor  = falling_count_q;
				div_steps    = StepWidth'(SumWidth);
			end
			default: begin
				div_rem_init = '0;
				div_dividend = '0;
				div_divisor  = '0;
				div_steps    = '0;
			end
		endcase
	end

	zcpa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem_init),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.quotient (quotient),
		.done     (div_done)
	);

	// Output register.
	logic [MeanWidth-1:0]  mean_r_q;
	logic                  out_valid_q;
	logic [MeanWidth-1:0]  mean_rising_q, mean_falling_q;
	logic [CountWidth-1:0] rising_total_q, falling_total_q;
	logic                  rising_valid_q, falling_valid_q;
	logic                  out_free;

	assign out_free = !out_valid_q || averages.ready;

	always_ff @(posedge clk) begin
		if (cmd.cap_mean_r) begin
			mean_r_q <= quotient[MeanWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (averages.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An empty count reports a zero mean whatever the divider produced.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_rising_q   <= (rising_count_q != '0) ? mean_r_q : '0;
			mean_falling_q  <= (falling_count_q != '0) ? quotient[MeanWidth-1:0] : '0;
			rising_total_q  <= rising_count_q;
			falling_total_q <= falling_count_q;
			rising_valid_q  <= rising_count_q != '0;
			falling_valid_q <= falling_count_q != '0;
		end
	end

	assign averages.valid         = out_valid_q;
	assign averages.mean_rising   = mean_rising_q;
	assign averages.mean_falling  = mean_falling_q;
	assign averages.rising_total  = rising_total_q;
	assign averages.falling_total = falling_total_q;
	assign averages.rising_valid  = rising_valid_q;
	assign averages.falling_valid = falling_valid_q;

	always_comb begin
		status.in_valid = samples.valid;
		status.hit      = rise_q || fall_q;
		status.last     = last_q;
		status.div_done = div_done;
		status.out_free = out_free;
	end

endmodule

// ===== design/zcpa_ctrl.sv =====
// Controller of the zero-crossing plane average block.
// Sequences item acceptance, the fraction division, accumulation, the two
// mean divisions and the result hand-off. Depends on zcpa_pkg.
module zcpa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  zcpa_pkg::dp_status_t  status,
	output zcpa_pkg::ctrl_cmd_t   cmd
);
	import zcpa_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.in_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (status.hit) state_next = ST_FRAC;
				else if (status.last)    state_next = ST_MEAN_START;
				else                     state_next = ST_IDLE;
			end
			ST_FRAC: begin
				if (status.div_done) state_next = status.last ? ST_MEAN_START : ST_IDLE;
			end
			ST_MEAN_START: state_next = ST_MEAN_R;
			ST_MEAN_R: begin
				if (status.div_done) state_next = ST_MEAN_F;
			end
			ST_MEAN_F: begin
				if (status.div_done) state_next = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{in_ready: 1'b0, div_start: 1'b0, div_sel: DIV_FRAC, accumulate: 1'b0,
		        cap_mean_r: 1'b0, load_out: 1'b0, clear_acc: 1'b0};
		unique case (state_q)
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_CHECK: begin
				if (status.hit) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_FRAC;
				end
			end
			ST_FRAC: begin
				if (status.div_done) cmd.accumulate = 1'b1;
			end
			ST_MEAN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN_R;
			end
			ST_MEAN_R: begin
				// The rising mean is captured on the same edge that restarts
				// the divider for the falling mean.
				if (status.div_done) begin
					cmd.cap_mean_r = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_sel    = DIV_MEAN_F;
				end
			end
			ST_MEAN_F: cmd.div_sel = DIV_MEAN_F;
			ST_OUT: begin
				cmd.div_sel = DIV_MEAN_F;
				if (status.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.clear_acc = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/zero_crossing_plane_average.sv =====
// Zero-crossing plane average: each item is a pair of vertically adjacent
// samples; pairs inside the column window and plane range that cross zero add
// their interpolated crossing position to a rising or falling sum. One item is
// in work at a time. An item that holds a crossing is held for its fraction
// division on the shared divider, which develops one quotient bit per cycle.
// An item marked last adds two 42-step mean divisions on the same divider,
// and its result then waits in an output register while new items are taken.
// Depends on zcpa_pkg, zcpa_if, zcpa_ctrl and zcpa_datapath.
module zero_crossing_plane_average #(
	parameter int PLANES        = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	zcpa_in_if.sink                             samples,
	zcpa_out_if.source                          averages,
	input  logic                                cfg_write_en,
	input  logic [zcpa_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [zcpa_pkg::CfgDataWidth-1:0]   cfg_data
);
	import zcpa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	zcpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	zcpa_datapath #(
		.PLANES        (PLANES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples),
		.averages     (averages),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

// ===== verif/tb_zero_crossing_plane_average.sv =====
// Testbench for zero_crossing_plane_average: directed and random item sets, checked
// against a predictor of the crossing sums, counts and means kept in this file.
// Depends on zcpa_pkg, zcpa_if and the zero_crossing_plane_average RTL.
module tb_zero_crossing_plane_average;
	timeunit 1ns;
	timeprecision 1ps;

	import zcpa_pkg::*;

	localparam int Planes       = 1024;
	localparam int FracBits     = 8;
	localparam int SettleCycles = 40;
	localparam int PhaseItems   = 75;
	localparam int RandomPhases = 10;

	typedef struct packed {
		logic signed [SampleWidth-1:0] lower;
		logic signed [SampleWidth-1:0] upper;
		logic [PlaneWidth-1:0]         plane;
		logic [CoordWidth-1:0]         col_x;
		logic [CoordWidth-1:0]         col_y;
		logic                          last;
	} sample_pair_t;

	typedef struct packed {
		logic [MeanWidth-1:0]  mean_r;
		logic [MeanWidth-1:0]  mean_f;
		logic [CountWidth-1:0] total_r;
		logic [CountWidth-1:0] total_f;
		logic                  valid_r;
		logic                  valid_f;
	} plane_averages_t;

	logic clk;
	logic arst_n;
	logic                     cfg_write_en;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;

	zcpa_in_if  samples_if ();
	zcpa_out_if averages_if ();

	zero_crossing_plane_average #(
		.PLANES       (Planes),
		.FRACTION_BITS(FracBits)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_if),
		.averages    (averages_if),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Register copies and crossing accumulators of the predictor.
	logic [CoordWidth-1:0] cen_x, cen_y;
	logic [HalfWidth-1:0]  half_x, half_y;
	logic [PlaneWidth-1:0] plane_lo, plane_hi;
	logic [SumWidth-1:0]   rise_sum, fall_sum;
	logic [CountWidth-1:0] rise_count, fall_count;

	plane_averages_t pending_averages[$];
	int  errors = 0;
	bit  in_gaps = 1'b1;
	bit  out_stalls = 1'b1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int idle_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic bit in_span(int c, int center, int half);
		return c >= center - half && c <= center + half;
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		errors++;
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	// Folds one accepted pair into the sums; a last pair queues the averages it closes.
	task automatic fold_pair(input sample_pair_t p);
		int lo, up;
		longint num, other, frac;
		logic [SumWidth-1:0] pos;
		bit examined;
		plane_averages_t res;
		lo = int'(p.lower);
		up = int'(p.upper);
		examined = in_span(int'(p.col_x), int'(cen_x), int'(half_x))
			&& in_span(int'(p.col_y), int'(cen_y), int'(half_y))
			&& p.plane >= plane_lo && p.plane <= plane_hi;
		if (examined && ((lo <= 0 && up > 0) || (lo >= 0 && up < 0))) begin
			num = (lo < 0) ? -lo : lo;
			other = (up < 0) ? -up : up;
			frac = (num << FracBits) / (num + other);
			pos = (SumWidth'(p.plane) << FracBits) + SumWidth'(frac);
			if (up > 0) begin
				if (rise_count < CountMax) begin
					rise_sum = rise_sum + pos;
					rise_count = rise_count + 1'b1;
				end
			end else if (fall_count < CountMax) begin
				fall_sum = fall_sum + pos;
				fall_count = fall_count + 1'b1;
			end
		end
		if (p.last) begin
			res.mean_r = (rise_count != 0) ? MeanWidth'(rise_sum / rise_count) : '0;
			res.mean_f = (fall_count != 0) ? MeanWidth'(fall_sum / fall_count) : '0;
			res.total_r = rise_count;
			res.total_f = fall_count;
			res.valid_r = rise_count != 0;
			res.valid_f = fall_count != 0;
			pending_averages.push_back(res);
			rise_sum = '0;
			fall_sum = '0;
			rise_count = '0;
			fall_count = '0;
		end
	endtask

	task automatic send_item(input sample_pair_t p);
		int gap;
		gap = (in_gaps && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.lower_sample <= p.lower;
		samples_if.upper_sample <= p.upper;
		samples_if.plane_index  <= p.plane;
		samples_if.column_x     <= p.col_x;
		samples_if.column_y     <= p.col_y;
		samples_if.last_item    <= p.last;
		samples_if.valid        <= 1'b1;
		do @(posedge clk); while (!samples_if.ready);
		fold_pair(p);
	endtask

	task automatic send_pair(input int lower, input int upper, input int plane,
		input int col_x, input int col_y, input bit last);
		sample_pair_t p;
		p.lower = SampleWidth'(lower);
		p.upper = SampleWidth'(upper);
		p.plane = PlaneWidth'(plane);
		p.col_x = CoordWidth'(col_x);
		p.col_y = CoordWidth'(col_y);
		p.last  = last;
		send_item(p);
	endtask

	// Stops the sender until every queued average has come out, then lets the
	// block finish any pair still in work.
	task automatic drain_pipeline(input int extra);
		@(negedge clk);
		samples_if.valid <= 1'b0;
		wait (pending_averages.size() == 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] index, input int unsigned value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= index;
		cfg_data     <= CfgDataWidth'(value);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		unique case (index)
			CfgCenterX:    cen_x = CoordWidth'(value);
			CfgCenterY:    cen_y = CoordWidth'(value);
			CfgHalfX:      half_x = HalfWidth'(value);
			CfgHalfY:      half_y = HalfWidth'(value);
			CfgFirstPlane: plane_lo = PlaneWidth'(value);
			CfgFinalPlane: plane_hi = PlaneWidth'(value);
			default: ;
		endcase
	endtask

	task automatic apply_config(input int cx, input int cy, input int hx, input int hy,
		input int first, input int final_p);
		drain_pipeline(SettleCycles);
		write_reg(CfgCenterX, cx);
		write_reg(CfgCenterY, cy);
		write_reg(CfgHalfX, hx);
		write_reg(CfgHalfY, hy);
		write_reg(CfgFirstPlane, first);
		write_reg(CfgFinalPlane, final_p);
	endtask

	task automatic test_reset_values();
		// Reset window is the single column (0,0); planes 10 through 1012 count.
		send_pair(-4096, 4096, 10, 0, 0, 0);
		send_pair(4096, -4096, 1012, 0, 0, 0);
		send_pair(-4096, 4096, 9, 0, 0, 0);
		send_pair(4096, -4096, 1013, 0, 0, 0);
		send_pair(-100, 300, 500, 1, 0, 0);
		send_pair(-100, 300, 500, 0, 1, 1);
		// A set without any crossing reports empty means.
		send_pair(200, 300, 500, 0, 0, 1);
	endtask

	task automatic test_window_edges();
		// Window bounds run below zero in x and above 1023 in y.
		apply_config(0, 1023, 511, 511, 0, 1022);
		send_pair(-32768, 32767, 0, 511, 512, 0);
		send_pair(32767, -32768, 1022, 0, 1023, 0);
		send_pair(0, 1, 300, 100, 900, 0);
		send_pair(0, -1, 301, 100, 900, 0);
		send_pair(-32768, 1, 302, 100, 900, 0);
		send_pair(0, 0, 303, 100, 900, 0);
		send_pair(-1, 0, 304, 100, 900, 0);
		send_pair(5, 7, 305, 100, 900, 0);
		send_pair(-20, 40, 306, 512, 900, 0);
		send_pair(-20, 40, 307, 100, 511, 1);
		// Zero half widths leave one column; a single-plane range.
		apply_config(1023, 0, 0, 0, 1022, 1022);
		send_pair(-3, 5, 1022, 1023, 0, 0);
		send_pair(7, -2, 1021, 1023, 0, 1);
	endtask

	task automatic test_inverted_range();
		apply_config(512, 512, 511, 511, 1022, 0);
		send_pair(-500, 500, 600, 512, 512, 0);
		send_pair(500, -500, 0, 512, 512, 1);
	endtask

	function automatic int rand_mag(int unsigned maxv);
		return int'($urandom_range(0, maxv) >> $urandom_range(0, 14));
	endfunction

	function automatic int edge_sample();
		unique case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic sample_pair_t make_pair(input bit last);
		sample_pair_t p;
		int lo_x, hi_x, lo_y, hi_y, lower, upper, kind;
		lo_x = int'(cen_x) - int'(half_x);
		hi_x = int'(cen_x) + int'(half_x);
		lo_y = int'(cen_y) - int'(half_y);
		hi_y = int'(cen_y) + int'(half_y);
		if (lo_x < 0) lo_x = 0;
		if (lo_y < 0) lo_y = 0;
		if (hi_x > 1023) hi_x = 1023;
		if (hi_y > 1023) hi_y = 1023;
		if ($urandom_range(0, 9) < 8) begin
			p.col_x = CoordWidth'($urandom_range(lo_x, hi_x));
			p.col_y = CoordWidth'($urandom_range(lo_y, hi_y));
		end else begin
			p.col_x = CoordWidth'($urandom_range(0, 1023));
			p.col_y = CoordWidth'($urandom_range(0, 1023));
		end
		if (plane_lo <= plane_hi && $urandom_range(0, 9) < 8)
			p.plane = PlaneWidth'($urandom_range(plane_lo, plane_hi));
		else
			p.plane = PlaneWidth'($urandom_range(0, 1022));
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			lower = -rand_mag(32768);
			upper = 1 + rand_mag(32766);
		end else if (kind < 8) begin
			lower = rand_mag(32767);
			upper = -1 - rand_mag(32767);
		end else if (kind == 8) begin
			lower = int'($urandom_range(0, 65535)) - 32768;
			upper = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			lower = edge_sample();
			upper = edge_sample();
		end
		p.lower = SampleWidth'(lower);
		p.upper = SampleWidth'(upper);
		p.last  = last;
		return p;
	endfunction

	task automatic random_config();
		int cx, cy, hx, hy, first, final_p, swap;
		cx = ($urandom_range(0, 6) == 0) ? 0 : ($urandom_range(0, 6) == 0) ? 1023
			: $urandom_range(0, 1023);
		cy = ($urandom_range(0, 6) == 0) ? 1023 : $urandom_range(0, 1023);
		hx = ($urandom_range(0, 5) == 0) ? 511 : ($urandom_range(0, 6) == 0) ? 0
			: $urandom_range(0, 511);
		hy = ($urandom_range(0, 5) == 0) ? 511 : $urandom_range(0, 511);
		first = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 1022);
		final_p = ($urandom_range(0, 4) == 0) ? 1022 : $urandom_range(first, 1022);
		if ($urandom_range(0, 9) == 0) begin
			swap = first;
			first = final_p;
			final_p = swap;
		end
		apply_config(cx, cy, hx, hy, first, final_p);
	endtask

	task automatic test_random_sets();
		int sent, set_len;
		for (int phase = 0; phase < RandomPhases; phase++) begin
			random_config();
			sent = 0;
			while (sent < PhaseItems) begin
				set_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
				in_gaps = $urandom_range(0, 3) != 0;
				out_stalls = $urandom_range(0, 3) != 0;
				// Hold the sender off until every pending set has reported.
				if ((phase == 0 && sent == 0) || $urandom_range(0, 19) == 0)
					drain_pipeline(0);
				for (int i = 0; i < set_len; i++)
					send_item(make_pair(i == set_len - 1));
				sent += set_len;
			end
		end
		in_gaps = 1'b1;
		out_stalls = 1'b1;
	endtask

	initial begin
		int run;
		bit level;
		run = 0;
		level = 1'b0;
		averages_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (run > 0)
				run--;
			else if (out_stalls && level && $urandom_range(0, 2) == 0) begin
				level = 1'b0;
				run = idle_gap() - 1;
			end else begin
				level = 1'b1;
				run = $urandom_range(0, 8);
			end
			averages_if.ready <= level;
		end
	end

	always @(posedge clk) begin
		plane_averages_t want;
		if (arst_n && averages_if.valid && averages_if.ready) begin
			if (pending_averages.size() == 0) begin
				report("unexpected averages items", 1, 0);
			end else begin
				want = pending_averages.pop_front();
				if (averages_if.mean_rising !== want.mean_r)
					report("mean_rising", averages_if.mean_rising, want.mean_r);
				if (averages_if.mean_falling !== want.mean_f)
					report("mean_falling", averages_if.mean_falling, want.mean_f);
				if (averages_if.rising_total !== want.total_r)
					report("rising_total", averages_if.rising_total, want.total_r);
				if (averages_if.falling_total !== want.total_f)
					report("falling_total", averages_if.falling_total, want.total_f);
				if (averages_if.rising_valid !== want.valid_r)
					report("rising_valid", averages_if.rising_valid, want.valid_r);
				if (averages_if.falling_valid !== want.valid_f)
					report("falling_valid", averages_if.falling_valid, want.valid_f);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.lower_sample = '0;
		samples_if.upper_sample = '0;
		samples_if.plane_index = '0;
		samples_if.column_x = '0;
		samples_if.column_y = '0;
		samples_if.last_item = 1'b0;
		cen_x = '0;
		cen_y = '0;
		half_x = '0;
		half_y = '0;
		plane_lo = PlaneWidth'(FirstPlaneReset);
		plane_hi = PlaneWidth'(Planes - FinalPlaneMargin);
		rise_sum = '0;
		fall_sum = '0;
		rise_count = '0;
		fall_count = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_window_edges();
		test_inverted_range();
		test_random_sets();

		drain_pipeline(SettleCycles);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
